[hdl/hirfb_pkg.sv]
// shared types, constants and microcode rom for the ir command frame builder
// no dependencies; imported by every module of the block
`default_nettype none

package hirfb_pkg;

    // setpoint limits and the code offset
    localparam logic [7:0] TEMP_F_MIN = 8'd60;
    localparam logic [7:0] TEMP_F_MAX = 8'd88;
    localparam logic [7:0] TEMP_BASE  = 8'd60;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VANE     = 3'd4;

    // vane codes that turn swing on
    localparam logic [2:0] VANE_AUTO      = 3'd0;
    localparam logic [2:0] VANE_AUTO_MOVE = 3'd6;

    // microcode program layout
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_DISPATCH = 5'd0;
    localparam logic [STEP_W-1:0] STEP_LONG     = 5'd8;

    typedef enum logic [1:0] {
        OP_BRANCH,  // wait for a request, then go to the off or long program
        OP_NEXT,    // emit and step on
        OP_JUMP     // emit and jump to target
    } seq_op_t;

    typedef enum logic [2:0] {
        SRC_LIT,
        SRC_TEMP,
        SRC_MODE,
        SRC_FAN,
        SRC_CSUM
    } src_t;

    typedef struct packed {
        seq_op_t           op;
        logic [STEP_W-1:0] target;
        src_t              src;
        logic [7:0]        lit;
        logic [3:0]        idx;
        logic              emit;
        logic              long_f;
        logic              last_f;
        logic              add;
        logic              clr_pend;
    } ucw_t;

    // sequencer to datapath
    typedef struct packed {
        ucw_t cw;
        logic start;
    } ctl_t;

    // datapath to sequencer
    typedef struct packed {
        logic power_on;
        logic out_free;
    } stat_t;

    function automatic ucw_t hirfb_emit(input src_t s, input logic [7:0] lit,
                                        input logic [3:0] idx, input logic lng,
                                        input logic add, input logic last_f);
        ucw_t w;
        w.op       = last_f ? OP_JUMP : OP_NEXT;
        w.target   = STEP_DISPATCH;
        w.src      = s;
        w.lit      = lit;
        w.idx      = idx;
        w.emit     = 1'b1;
        w.long_f   = lng;
        w.last_f   = last_f;
        w.add      = add;
        w.clr_pend = lng & last_f;
        return w;
    endfunction

    function automatic ucw_t hirfb_dispatch();
        ucw_t w;
        w          = '0;
        w.op       = OP_BRANCH;
        w.target   = STEP_LONG;
        w.src      = SRC_LIT;
        return w;
    endfunction

    // control store: dispatch, off frame, long frame
    function automatic ucw_t hirfb_ucode(input logic [STEP_W-1:0] step);
        ucw_t w;
        case (step)
            5'd0:    w = hirfb_dispatch();
            5'd1:    w = hirfb_emit(SRC_LIT,  8'h14, 4'd0,  1'b0, 1'b0, 1'b0);
            5'd2:    w = hirfb_emit(SRC_LIT,  8'h63, 4'd1,  1'b0, 1'b0, 1'b0);
            5'd3:    w = hirfb_emit(SRC_LIT,  8'h00, 4'd2,  1'b0, 1'b0, 1'b0);
            5'd4:    w = hirfb_emit(SRC_LIT,  8'h10, 4'd3,  1'b0, 1'b0, 1'b0);
            5'd5:    w = hirfb_emit(SRC_LIT,  8'h10, 4'd4,  1'b0, 1'b0, 1'b0);
            5'd6:    w = hirfb_emit(SRC_LIT,  8'h02, 4'd5,  1'b0, 1'b0, 1'b0);
            5'd7:    w = hirfb_emit(SRC_LIT,  8'hFD, 4'd6,  1'b0, 1'b0, 1'b1);
            5'd8:    w = hirfb_emit(SRC_LIT,  8'h14, 4'd0,  1'b1, 1'b0, 1'b0);
            5'd9:    w = hirfb_emit(SRC_LIT,  8'h63, 4'd1,  1'b1, 1'b0, 1'b0);
            5'd10:   w = hirfb_emit(SRC_LIT,  8'h00, 4'd2,  1'b1, 1'b0, 1'b0);
            5'd11:   w = hirfb_emit(SRC_LIT,  8'h10, 4'd3,  1'b1, 1'b0, 1'b0);
            5'd12:   w = hirfb_emit(SRC_LIT,  8'h10, 4'd4,  1'b1, 1'b0, 1'b0);
            5'd13:   w = hirfb_emit(SRC_LIT,  8'hFE, 4'd5,  1'b1, 1'b0, 1'b0);
            5'd14:   w = hirfb_emit(SRC_LIT,  8'h09, 4'd6,  1'b1, 1'b0, 1'b0);
            5'd15:   w = hirfb_emit(SRC_LIT,  8'h30, 4'd7,  1'b1, 1'b1, 1'b0);
            5'd16:   w = hirfb_emit(SRC_TEMP, 8'h00, 4'd8,  1'b1, 1'b1, 1'b0);
            5'd17:   w = hirfb_emit(SRC_MODE, 8'h00, 4'd9,  1'b1, 1'b1, 1'b0);
            5'd18:   w = hirfb_emit(SRC_FAN,  8'h00, 4'd10, 1'b1, 1'b1, 1'b0);
            5'd19:   w = hirfb_emit(SRC_LIT,  8'h00, 4'd11, 1'b1, 1'b1, 1'b0);
            5'd20:   w = hirfb_emit(SRC_LIT,  8'h00, 4'd12, 1'b1, 1'b1, 1'b0);
            5'd21:   w = hirfb_emit(SRC_LIT,  8'h00, 4'd13, 1'b1, 1'b1, 1'b0);
            5'd22:   w = hirfb_emit(SRC_LIT,  8'h20, 4'd14, 1'b1, 1'b1, 1'b0);
            5'd23:   w = hirfb_emit(SRC_CSUM, 8'h00, 4'd15, 1'b1, 1'b0, 1'b1);
            default: w = hirfb_dispatch();
        endcase
        return w;
    endfunction

    function automatic logic [7:0] hirfb_mode_code(input logic [2:0] mode);
        logic [7:0] c;
        case (mode)
            3'd0:    c = 8'h04;  // heat
            3'd1:    c = 8'h01;  // cool
            3'd2:    c = 8'h02;  // dry
            3'd4:    c = 8'h03;  // fan
            default: c = 8'h00;  // auto and unknown
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hirfb_fan_code(input logic [2:0] fan);
        logic [7:0] c;
        case (fan)
            3'd1:    c = 8'h04;
            3'd2:    c = 8'h03;
            3'd3:    c = 8'h02;
            3'd4:    c = 8'h01;
            3'd5:    c = 8'h04;  // silent
            default: c = 8'h00;  // auto and unknown
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/hvac_ir_frame_builder_top.sv]
// a request transaction moves the step counter to the first byte step; that byte is loaded into
// the output register once it is free. A frame is one dispatch step plus one microcode step per
// byte; the step counter walks one control word per cycle and holds while the output register
// is stalled
// reset: settings return to power on, auto mode, auto fan, 70 F, auto vane; the
// power-on pending flag is set and the sequencer waits at its dispatch step
`default_nettype none

module hvac_ir_frame_builder_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request channel
    input  wire logic                               send_valid,
    output logic                                    send_stall,
    input  wire logic                               send_request,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [hirfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [7:0]                         cfg_data,
    // frame byte channel
    output logic                                    byte_valid,
    input  wire logic                               byte_stall,
    output logic [7:0]                              frame_byte,
    output logic [3:0]                              byte_index,
    output logic                                    long_frame,
    output logic                                    last_byte
);
    import hirfb_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    // control store and step counter; a request transaction is taken only at the
    // dispatch step, which branches to the off or the long frame program
    hirfb_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .send_valid   (send_valid),
        .send_request (send_request),
        .send_stall   (send_stall),
        .stat         (stat),
        .ctl          (ctl)
    );

    // settings, byte select, running checksum over bytes 7 to 14, output register
    hirfb_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ctl        (ctl),
        .stat       (stat),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .long_frame (long_frame),
        .last_byte  (last_byte)
    );

endmodule

`default_nettype wire

[hdl/hirfb_sequencer.sv]
// microcode sequencer: step counter, control store lookup and jumps
// depends on hirfb_pkg
`default_nettype none

module hirfb_sequencer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           send_valid,
    input  wire logic           send_request,
    output logic                send_stall,
    input  wire hirfb_pkg::stat_t stat,
    output hirfb_pkg::ctl_t     ctl
);
    import hirfb_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucw_t              cw;
    logic              go;

    assign cw         = hirfb_ucode(step_reg);
    assign send_stall = (cw.op != OP_BRANCH);
    assign go         = (cw.op == OP_BRANCH) && send_valid && send_request;

    always_comb
    begin
        step_next = step_reg;
        case (cw.op)
            OP_BRANCH:
            begin
                if (go)
                begin
                    step_next = stat.power_on ? cw.target : STEP_W'(step_reg + 1'b1);
                end
            end
            OP_NEXT:
            begin
                if (stat.out_free)
                begin
                    step_next = STEP_W'(step_reg + 1'b1);
                end
            end
            OP_JUMP:
            begin
                if (stat.out_free)
                begin
                    step_next = cw.target;
                end
            end
            default: step_next = STEP_DISPATCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_DISPATCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctl.cw    = cw;
    assign ctl.start = go;

endmodule

`default_nettype wire

[hdl/hirfb_datapath.sv]
// datapath: settings registers, byte select, checksum accumulator, output register
// depends on hirfb_pkg
`default_nettype none

module hirfb_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [hirfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [7:0]                         cfg_data,
    input  wire hirfb_pkg::ctl_t                    ctl,
    output hirfb_pkg::stat_t                        stat,
    output logic                                    byte_valid,
    input  wire logic                               byte_stall,
    output logic [7:0]                              frame_byte,
    output logic [3:0]                              byte_index,
    output logic                                    long_frame,
    output logic                                    last_byte
);
    import hirfb_pkg::*;

    logic       power_reg, power_next;
    logic [2:0] mode_reg, mode_next;
    logic [2:0] fan_reg, fan_next;
    logic [7:0] setpoint_reg, setpoint_next;
    logic [2:0] vane_reg, vane_next;
    logic       pend_reg, pend_next;
    logic [7:0] sum_reg, sum_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [3:0] idx_reg, idx_next;
    logic       long_reg, long_next;
    logic       last_reg, last_next;

    logic              out_free;
    logic              fire;
    logic [7:0]        temp_c;
    logic signed [8:0] temp_d;
    logic [8:0]        temp_mag;
    logic [8:0]        temp_q;
    logic [8:0]        temp_qs;
    logic [7:0]        temp_byte;
    logic              swing;
    logic [7:0]        sel_byte;

    assign out_free = !valid_reg || !byte_stall;
    assign fire     = ctl.cw.emit && out_free;

    // clamp, offset, halve toward zero, shift into the high nibble
    always_comb
    begin
        if (setpoint_reg < TEMP_F_MIN)
        begin
            temp_c = TEMP_F_MIN;
        end
        else if (setpoint_reg > TEMP_F_MAX)
        begin
            temp_c = TEMP_F_MAX;
        end
        else
        begin
            temp_c = setpoint_reg;
        end
        temp_d    = $signed({1'b0, temp_c}) - $signed({1'b0, TEMP_BASE});
        temp_mag  = temp_d[8] ? 9'(-temp_d) : 9'(temp_d);
        temp_q    = temp_mag >> 1;
        temp_qs   = temp_d[8] ? 9'(-temp_q) : temp_q;
        temp_byte = {temp_qs[3:0], 4'b0000};
    end

    assign swing = (vane_reg == VANE_AUTO) || (vane_reg == VANE_AUTO_MOVE);

    always_comb
    begin
        case (ctl.cw.src)
            SRC_LIT:  sel_byte = ctl.cw.lit;
            SRC_TEMP: sel_byte = temp_byte | {7'b0, pend_reg};
            SRC_MODE: sel_byte = hirfb_mode_code(mode_reg);
            SRC_FAN:  sel_byte = hirfb_fan_code(fan_reg) | {3'b0, swing, 4'b0};
            SRC_CSUM: sel_byte = 8'(8'd0 - sum_reg);
            default:  sel_byte = ctl.cw.lit;
        endcase
    end

    always_comb
    begin
        power_next    = power_reg;
        mode_next     = mode_reg;
        fan_next      = fan_reg;
        setpoint_next = setpoint_reg;
        vane_next     = vane_reg;
        pend_next     = pend_reg;
        sum_next      = sum_reg;
        valid_next    = valid_reg;
        byte_next     = byte_reg;
        idx_next      = idx_reg;
        long_next     = long_reg;
        last_next     = last_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_POWER:
                begin
                    if (cfg_data[0] && !power_reg)
                    begin
                        pend_next = 1'b1;
                    end
                    power_next = cfg_data[0];
                end
                CFG_MODE:     mode_next     = cfg_data[2:0];
                CFG_FAN:      fan_next      = cfg_data[2:0];
                CFG_SETPOINT: setpoint_next = cfg_data;
                CFG_VANE:     vane_next     = cfg_data[2:0];
                default:      ;
            endcase
        end

        if (ctl.start)
        begin
            sum_next = 8'd0;
        end

        if (valid_reg && !byte_stall)
        begin
            valid_next = 1'b0;
        end

        if (fire)
        begin
            valid_next = 1'b1;
            byte_next  = sel_byte;
            idx_next   = ctl.cw.idx;
            long_next  = ctl.cw.long_f;
            last_next  = ctl.cw.last_f;
            if (ctl.cw.add)
            begin
                sum_next = 8'(sum_reg + sel_byte);
            end
            if (ctl.cw.clr_pend)
            begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg    <= 1'b1;
            mode_reg     <= 3'd3;
            fan_reg      <= 3'd0;
            setpoint_reg <= 8'd70;
            vane_reg     <= 3'd0;
            pend_reg     <= 1'b1;
            sum_reg      <= 8'd0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            power_reg    <= power_next;
            mode_reg     <= mode_next;
            fan_reg      <= fan_next;
            setpoint_reg <= setpoint_next;
            vane_reg     <= vane_next;
            pend_reg     <= pend_next;
            sum_reg      <= sum_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        idx_reg  <= idx_next;
        long_reg <= long_next;
        last_reg <= last_next;
    end

    assign stat.power_on = power_reg;
    assign stat.out_free = out_free;
    assign byte_valid    = valid_reg;
    assign frame_byte    = byte_reg;
    assign byte_index    = idx_reg;
    assign long_frame    = long_reg;
    assign last_byte     = last_reg;

endmodule

`default_nettype wire
